@@ rtl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment table for the two-wire
// seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int DIGITS      = 4;

  localparam int POS_W   = $clog2(FRAME_BYTES + 1);
  localparam int SLOT_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int CNT_W   = $clog2(DIGITS + 1);
  localparam int WSLOT_W = $clog2(FRAME_BYTES + DIGITS + 2);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CMD_AUTO  = 8'h40;
  localparam logic [7:0] SEG_MINUS = 8'h40;

  // divide by ten: q = (m * 52429) >> 19, exact for m < 43699
  localparam logic [15:0] RECIP       = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_NUMBER = 2'd1,
    ACT_RAW    = 2'd2,
    ACT_BRIGHT = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CV_IDLE  = 2'd0,
    CV_DIGIT = 2'd1,
    CV_MINUS = 2'd2
  } conv_state_t;

  // queued word: number words carry {neg, magnitude} in data[15:0]
  typedef struct packed {
    act_t        act;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [14:0] mag;
  } conv_start_t;

  typedef struct packed {
    logic               en;
    logic [WSLOT_W-1:0] slot;
    logic [7:0]         data;
  } frame_wr_t;

  function automatic logic [7:0] digit_code(input logic [3:0] d);
    logic [7:0] seg;
    unique case (d)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/ssd_front.sv @@
// ----------------------------------------------------------------------------
// ssd_front
// Accepts input words, classifies them by action and queues them.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [14:0] in_number,
  input  logic [31:0]        in_raw_segments,
  input  logic [7:0]         in_brightness_byte,
  output logic               q_valid,
  output ssd_pkg::cmd_t      q_cmd,
  input  logic               q_pop
);

  ssd_pkg::cmd_t                     fifo_r [ssd_pkg::QDEPTH];
  logic [ssd_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [ssd_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [ssd_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  ssd_pkg::cmd_t                     cls;
  logic [14:0]                       num_u;
  logic [14:0]                       mag;
  logic                              push;

  assign num_u = in_number;
  assign mag   = num_u[14] ? (~num_u + 15'd1) : num_u;

  always_comb begin
    cls.act = ssd_pkg::act_t'(in_action);
    unique case (cls.act)
      ssd_pkg::ACT_TICK:   cls.data = '0;
      ssd_pkg::ACT_NUMBER: cls.data = {16'd0, num_u[14], mag};
      ssd_pkg::ACT_RAW:    cls.data = in_raw_segments;
      ssd_pkg::ACT_BRIGHT: cls.data = {24'd0, in_brightness_byte};
      default:             cls.data = '0;
    endcase
  end

  assign in_ready = (cnt_r != ssd_pkg::QCNT_W'(ssd_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ssd_pkg::QPTR_W'(ssd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssd_pkg::QPTR_W'(ssd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (q_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/ssd_digit_conv.sv @@
// ----------------------------------------------------------------------------
// ssd_digit_conv
// Turns a magnitude into segment codes, one decimal digit per cycle,
// least significant first, then an optional minus sign.
// ----------------------------------------------------------------------------
module ssd_digit_conv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssd_pkg::conv_start_t conv_start,
  output ssd_pkg::frame_wr_t   conv_wr,
  output logic                 conv_busy
);

  ssd_pkg::conv_state_t          state_r, state_nxt;
  logic [14:0]                   mag_r, mag_nxt;
  logic                          neg_r, neg_nxt;
  logic [ssd_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [ssd_pkg::CNT_W-1:0]     n_inc;
  logic [30:0]                   prod;
  logic [14:0]                   quo;
  logic [14:0]                   ten_q;
  logic [14:0]                   rem_full;
  logic [ssd_pkg::WSLOT_W-1:0]   slot;
  logic                          last;

  assign prod     = 31'(mag_r) * 31'(ssd_pkg::RECIP);
  assign quo      = 15'(prod >> ssd_pkg::RECIP_SHIFT);
  assign ten_q    = 15'({quo, 3'b000}) + 15'({quo, 1'b0});
  assign rem_full = mag_r - ten_q;
  assign n_inc    = n_r + 1'b1;
  assign slot     = ssd_pkg::WSLOT_W'(n_r) + 1'b1;
  assign last     = (quo == '0) || (n_inc == ssd_pkg::CNT_W'(ssd_pkg::DIGITS));

  always_comb begin
    state_nxt = state_r;
    if (conv_start.start) begin
      state_nxt = ssd_pkg::CV_DIGIT;
    end else begin
      unique case (state_r)
        ssd_pkg::CV_IDLE:  state_nxt = ssd_pkg::CV_IDLE;
        ssd_pkg::CV_DIGIT: begin
          if (last) begin
            state_nxt = (neg_r && (n_inc < ssd_pkg::CNT_W'(ssd_pkg::DIGITS))) ?
                        ssd_pkg::CV_MINUS : ssd_pkg::CV_IDLE;
          end
        end
        ssd_pkg::CV_MINUS: state_nxt = ssd_pkg::CV_IDLE;
        default:           state_nxt = ssd_pkg::CV_IDLE;
      endcase
    end
  end

  always_comb begin
    conv_wr   = '0;
    conv_busy = (state_r != ssd_pkg::CV_IDLE);
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    n_nxt     = n_r;
    unique case (state_r)
      ssd_pkg::CV_IDLE: ;
      ssd_pkg::CV_DIGIT: begin
        conv_wr.en   = (slot < ssd_pkg::WSLOT_W'(ssd_pkg::FRAME_BYTES));
        conv_wr.slot = slot;
        conv_wr.data = ssd_pkg::digit_code(rem_full[3:0]);
        mag_nxt      = quo;
        n_nxt        = n_inc;
      end
      ssd_pkg::CV_MINUS: begin
        conv_wr.en   = (slot < ssd_pkg::WSLOT_W'(ssd_pkg::FRAME_BYTES));
        conv_wr.slot = slot;
        conv_wr.data = ssd_pkg::SEG_MINUS;
      end
      default: ;
    endcase
    if (conv_start.start) begin
      mag_nxt = conv_start.mag;
      neg_nxt = conv_start.neg;
      n_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssd_pkg::CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    n_r   <= n_nxt;
  end

endmodule

@@ rtl/ssd_back.sv @@
// ----------------------------------------------------------------------------
// ssd_back
// Executes queued words: loads frames, steps the two-wire waveform one
// half bit per tick and registers one result word per queued word.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ssd_pkg::cmd_t        q_cmd,
  output logic                 q_pop,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_clock_line,
  output logic                 out_data_line,
  output logic                 out_busy_res,
  output logic                 out_frame_done,
  output logic                 out_rejected,
  output ssd_pkg::conv_start_t conv_start,
  input  ssd_pkg::frame_wr_t   conv_wr,
  output ssd_pkg::phase_t      phase
);

  ssd_pkg::phase_t              phase_r, phase_nxt;
  logic                         half_r, half_nxt;
  logic [ssd_pkg::POS_W-1:0]    byte_pos_r, byte_pos_nxt;
  logic [ssd_pkg::POS_W-1:0]    byte_inc;
  logic [3:0]                   bit_pos_r, bit_pos_nxt;
  logic [ssd_pkg::POS_W-1:0]    len_r, len_nxt;
  logic                         clk_lvl_r, clk_lvl_nxt;
  logic                         dat_lvl_r, dat_lvl_nxt;
  logic [7:0]                   store_r   [ssd_pkg::FRAME_BYTES];
  logic [7:0]                   store_nxt [ssd_pkg::FRAME_BYTES];
  logic                         tx_bit;
  logic                         do_tick, do_load, do_rej, done;
  logic                         byte_end;
  logic                         out_valid_r;
  logic                         out_clk_r, out_dat_r, out_busy_r, out_done_r, out_rej_r;

  assign q_pop    = q_valid && (!out_valid_r || out_ready);
  assign do_tick  = q_pop && (q_cmd.act == ssd_pkg::ACT_TICK);
  assign do_load  = q_pop && (q_cmd.act != ssd_pkg::ACT_TICK) && (phase_r == ssd_pkg::PH_IDLE);
  assign do_rej   = q_pop && (q_cmd.act != ssd_pkg::ACT_TICK) && (phase_r != ssd_pkg::PH_IDLE);
  assign byte_inc = byte_pos_r + 1'b1;
  assign byte_end = (bit_pos_r == 4'd8);
  assign tx_bit   = (bit_pos_r < 4'd8) ?
                    store_r[byte_pos_r[ssd_pkg::SLOT_W-1:0]][bit_pos_r[2:0]] : 1'b0;
  assign phase    = phase_r;

  // {start, neg, mag}
  assign conv_start = {do_load && (q_cmd.act == ssd_pkg::ACT_NUMBER),
                       q_cmd.data[15], q_cmd.data[14:0]};

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (do_load) begin
      phase_nxt = ssd_pkg::PH_START;
    end else if (do_tick) begin
      unique case (phase_r)
        ssd_pkg::PH_IDLE:  phase_nxt = ssd_pkg::PH_IDLE;
        ssd_pkg::PH_START: if (half_r) phase_nxt = ssd_pkg::PH_DATA;
        ssd_pkg::PH_DATA: begin
          if (half_r && byte_end && (byte_inc >= len_r)) begin
            phase_nxt = ssd_pkg::PH_STOP;
          end
        end
        ssd_pkg::PH_STOP:  if (half_r) phase_nxt = ssd_pkg::PH_IDLE;
        default:           phase_nxt = ssd_pkg::PH_IDLE;
      endcase
    end
  end

  // wire levels and counters
  always_comb begin
    half_nxt     = half_r;
    byte_pos_nxt = byte_pos_r;
    bit_pos_nxt  = bit_pos_r;
    len_nxt      = len_r;
    clk_lvl_nxt  = clk_lvl_r;
    dat_lvl_nxt  = dat_lvl_r;
    done         = 1'b0;
    if (do_load) begin
      half_nxt     = 1'b0;
      byte_pos_nxt = '0;
      bit_pos_nxt  = '0;
      len_nxt      = (q_cmd.act == ssd_pkg::ACT_BRIGHT) ?
                     ssd_pkg::POS_W'(1) : ssd_pkg::POS_W'(ssd_pkg::FRAME_BYTES);
    end else if (do_tick) begin
      unique case (phase_r)
        ssd_pkg::PH_IDLE: ;
        ssd_pkg::PH_START: begin
          if (!half_r) begin
            dat_lvl_nxt = 1'b0;
            half_nxt    = 1'b1;
          end else begin
            clk_lvl_nxt  = 1'b0;
            half_nxt     = 1'b0;
            byte_pos_nxt = '0;
            bit_pos_nxt  = '0;
          end
        end
        ssd_pkg::PH_DATA: begin
          if (!half_r) begin
            dat_lvl_nxt = tx_bit;
            clk_lvl_nxt = 1'b1;
            half_nxt    = 1'b1;
          end else begin
            clk_lvl_nxt = 1'b0;
            half_nxt    = 1'b0;
            if (byte_end) begin
              bit_pos_nxt  = '0;
              byte_pos_nxt = byte_inc;
            end else begin
              bit_pos_nxt = bit_pos_r + 1'b1;
            end
          end
        end
        ssd_pkg::PH_STOP: begin
          if (!half_r) begin
            clk_lvl_nxt = 1'b1;
            half_nxt    = 1'b1;
          end else begin
            dat_lvl_nxt = 1'b1;
            half_nxt    = 1'b0;
            done        = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // frame store
  always_comb begin
    store_nxt = store_r;
    if (do_load) begin
      case (q_cmd.act)
        ssd_pkg::ACT_NUMBER: begin
          for (int i = 0; i < ssd_pkg::FRAME_BYTES; i++) begin
            store_nxt[i] = (i == 0) ? ssd_pkg::CMD_AUTO : 8'h00;
          end
        end
        ssd_pkg::ACT_RAW: begin
          for (int i = 0; i < ssd_pkg::FRAME_BYTES; i++) begin
            if (i == 0) begin
              store_nxt[i] = ssd_pkg::CMD_AUTO;
            end else if (i <= 4) begin
              store_nxt[i] = 8'(q_cmd.data >> (8 * (i - 1)));
            end else begin
              store_nxt[i] = 8'h00;
            end
          end
        end
        ssd_pkg::ACT_BRIGHT: store_nxt[0] = q_cmd.data[7:0];
        default: ;
      endcase
    end else if (conv_wr.en) begin
      for (int i = 0; i < ssd_pkg::FRAME_BYTES; i++) begin
        if (conv_wr.slot == ssd_pkg::WSLOT_W'(i)) begin
          store_nxt[i] = conv_wr.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ssd_pkg::PH_IDLE;
      half_r     <= 1'b0;
      byte_pos_r <= '0;
      bit_pos_r  <= '0;
      len_r      <= '0;
      clk_lvl_r  <= 1'b1;
      dat_lvl_r  <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      half_r     <= half_nxt;
      byte_pos_r <= byte_pos_nxt;
      bit_pos_r  <= bit_pos_nxt;
      len_r      <= len_nxt;
      clk_lvl_r  <= clk_lvl_nxt;
      dat_lvl_r  <= dat_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_clk_r  <= clk_lvl_nxt;
      out_dat_r  <= dat_lvl_nxt;
      out_busy_r <= (phase_nxt != ssd_pkg::PH_IDLE);
      out_done_r <= done;
      out_rej_r  <= do_rej;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_clock_line = out_clk_r;
  assign out_data_line  = out_dat_r;
  assign out_busy_res   = out_busy_r;
  assign out_frame_done = out_done_r;
  assign out_rejected   = out_rej_r;

endmodule

@@ rtl/seven_segment_two_wire_driver_core.sv @@
// ----------------------------------------------------------------------------
// seven_segment_two_wire_driver_core
// Four-digit seven-segment display driver over a clock/data two-wire line.
//
//   channel | ports                                             | dir
//   --------+---------------------------------------------------+-----
//   in      | in_valid/in_ready, in_action, in_number,          | in
//           | in_raw_segments, in_brightness_byte               |
//   out     | out_valid/out_ready, out_clock_line,              | out
//           | out_data_line, out_busy_res, out_frame_done,      |
//           | out_rejected                                      |
//
// One word per cycle sustained while the out side accepts; a result word is
// registered at the edge its input word leaves the two-entry queue.
// Show-number digits come from one reciprocal multiplier, one digit per cycle,
// well before the first digit byte is clocked out. Reset clears the queue,
// the wire sequencer and the result valid flag; the wire levels come up
// high. A stalled out side fills the queue, then drops in_ready.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_driver_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [14:0] in_number,
  input  logic [31:0]        in_raw_segments,
  input  logic [7:0]         in_brightness_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_clock_line,
  output logic               out_data_line,
  output logic               out_busy_res,
  output logic               out_frame_done,
  output logic               out_rejected
);

  logic                 q_valid;
  logic                 q_pop;
  ssd_pkg::cmd_t        q_cmd;
  ssd_pkg::conv_start_t conv_start;
  ssd_pkg::frame_wr_t   conv_wr;
  logic                 conv_busy;
  ssd_pkg::phase_t      phase;

  ssd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_number          (in_number),
    .in_raw_segments    (in_raw_segments),
    .in_brightness_byte (in_brightness_byte),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop)
  );

  ssd_digit_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .conv_start (conv_start),
    .conv_wr    (conv_wr),
    .conv_busy  (conv_busy)
  );

  ssd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_clock_line (out_clock_line),
    .out_data_line  (out_data_line),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done),
    .out_rejected   (out_rejected),
    .conv_start     (conv_start),
    .conv_wr        (conv_wr),
    .phase          (phase)
  );

  a_done_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (!out_busy_res && out_clock_line && out_data_line))
    else $error("frame done word without idle lines");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> (out_busy_res && !out_frame_done))
    else $error("rejected word while not busy");

  a_conv_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    conv_busy |-> (phase != ssd_pkg::PH_IDLE))
    else $error("digit conversion running outside a frame");

  a_conv_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    conv_start.start |-> (!conv_busy && phase == ssd_pkg::PH_IDLE))
    else $error("number load while conversion or frame active");

endmodule

@@ tb/tb_seven_segment_two_wire_driver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_two_wire_driver_core
// Self-checking bench for the two-wire seven-segment display driver. A short
// table of directed words (idle ticks, drops while busy, digit extremes, raw
// and brightness frames) runs first, then random frames with random content,
// stray commands and noise. A word-level line model predicts the result word
// of every word without a typed expectation; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_seven_segment_two_wire_driver_core;

  localparam int N_RANDOM_WORDS = 500;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } line_word_t;

  localparam line_word_t IDLE_LINES  = 5'b11000;
  localparam line_word_t CMD_TAKEN   = 5'b11100;
  localparam line_word_t CMD_DROPPED = 5'b11101;

  typedef struct {
    ssd_pkg::act_t act;
    logic [14:0]   num;
    logic [31:0]   raw;
    logic [7:0]    bright;
    int            reps;   // 0: tick until the frame is out
    logic          typed;
    line_word_t    want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = ssd_pkg::ACT_TICK;
  logic signed [14:0] in_number = '0;
  logic [31:0]        in_raw_segments = '0;
  logic [7:0]         in_brightness_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_clock_line;
  logic               out_data_line;
  logic               out_busy_res;
  logic               out_frame_done;
  logic               out_rejected;

  // line model state
  logic [7:0]      frame_bytes [ssd_pkg::FRAME_BYTES];
  int              frame_len = 0;
  int              byte_pos  = 0;
  int              bit_pos   = 0;
  logic            half      = 1'b0;
  ssd_pkg::phase_t wire_ph   = ssd_pkg::PH_IDLE;
  logic            clk_lv    = 1'b1;
  logic            dat_lv    = 1'b1;

  logic [7:0] seg_font [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
  string      field_name [5] = '{"rejected", "frame_done", "busy_res",
                                 "data_line", "clock_line"};

  line_word_t pending_lines [$];
  int         err_count  = 0;
  int         word_count = 0;
  int         ready_hold = 0;
  logic       calm       = 1'b0;

  dir_row_t dir_table [25] = '{
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 2, 1'b1, IDLE_LINES},
    '{ssd_pkg::ACT_NUMBER, 15'd0,      32'h0,        8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_NUMBER, 15'd1234,   32'h0,        8'h00, 1, 1'b1, CMD_DROPPED},
    '{ssd_pkg::ACT_RAW,    15'd0,      32'hFFFFFFFF, 8'h00, 1, 1'b1, CMD_DROPPED},
    '{ssd_pkg::ACT_BRIGHT, 15'd0,      32'h0,        8'hFF, 1, 1'b1, CMD_DROPPED},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_TICK,   15'h7FFF,   32'h0,        8'h00, 1, 1'b1, IDLE_LINES},
    '{ssd_pkg::ACT_NUMBER, 15'd9999,   32'h0,        8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_NUMBER, -15'sd9999, 32'h0,        8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_NUMBER, -15'sd7,    32'h0,        8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_NUMBER, 15'h3FFF,   32'h0,        8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_NUMBER, 15'h4000,   32'h0,        8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_RAW,    15'd0,      32'hFFFFFFFF, 8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_RAW,    15'd0,      32'h00000000, 8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_BRIGHT, 15'd0,      32'h0,        8'h00, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES},
    '{ssd_pkg::ACT_BRIGHT, 15'd0,      32'h0,        8'hFF, 1, 1'b1, CMD_TAKEN},
    '{ssd_pkg::ACT_TICK,   15'd0,      32'h0,        8'h00, 0, 1'b0, IDLE_LINES}
  };

  seven_segment_two_wire_driver_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_number          (in_number),
    .in_raw_segments    (in_raw_segments),
    .in_brightness_byte (in_brightness_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_clock_line     (out_clock_line),
    .out_data_line      (out_data_line),
    .out_busy_res       (out_busy_res),
    .out_frame_done     (out_frame_done),
    .out_rejected       (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [14:0] rand_number();
    int digs;
    int mag;
    if ($urandom_range(0, 9) == 0) begin
      return 15'($urandom);
    end
    digs = $urandom_range(1, 4);
    mag  = $urandom_range(0, (10 ** digs) - 1);
    return ($urandom_range(0, 1) == 1) ? 15'(-mag) : 15'(mag);
  endfunction

  function automatic void start_frame(input int len);
    frame_len = len;
    byte_pos  = 0;
    bit_pos   = 0;
    half      = 1'b0;
    wire_ph   = ssd_pkg::PH_START;
  endfunction

  // advances the line model by one accepted word and returns its result word
  function automatic line_word_t step_display(input ssd_pkg::act_t a, input logic [14:0] n,
                                              input logic [31:0] r, input logic [7:0] b);
    int unsigned mag;
    int          cnt;
    logic        neg;
    logic        done;
    logic        drop;
    line_word_t  w;
    done = 1'b0;
    drop = 1'b0;
    if (a == ssd_pkg::ACT_TICK) begin
      case (wire_ph)
        ssd_pkg::PH_START: begin
          if (!half) begin
            dat_lv = 1'b0;
            half   = 1'b1;
          end else begin
            clk_lv   = 1'b0;
            half     = 1'b0;
            byte_pos = 0;
            bit_pos  = 0;
            wire_ph  = ssd_pkg::PH_DATA;
          end
        end
        ssd_pkg::PH_DATA: begin
          if (!half) begin
            dat_lv = (bit_pos < 8 && byte_pos < ssd_pkg::FRAME_BYTES) ?
                     frame_bytes[byte_pos][bit_pos] : 1'b0;
            clk_lv = 1'b1;
            half   = 1'b1;
          end else begin
            clk_lv = 1'b0;
            half   = 1'b0;
            bit_pos++;
            if (bit_pos >= 9) begin
              bit_pos = 0;
              byte_pos++;
              if (byte_pos >= frame_len) begin
                wire_ph = ssd_pkg::PH_STOP;
              end
            end
          end
        end
        ssd_pkg::PH_STOP: begin
          if (!half) begin
            clk_lv = 1'b1;
            half   = 1'b1;
          end else begin
            dat_lv  = 1'b1;
            half    = 1'b0;
            wire_ph = ssd_pkg::PH_IDLE;
            done    = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (wire_ph != ssd_pkg::PH_IDLE) begin
      drop = 1'b1;
    end else if (a == ssd_pkg::ACT_NUMBER) begin
      neg = n[14];
      mag = neg ? (32'h8000 - {17'd0, n}) : {17'd0, n};
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      frame_bytes[0] = ssd_pkg::CMD_AUTO;
      cnt = 0;
      do begin
        if (1 + cnt < ssd_pkg::FRAME_BYTES) begin
          frame_bytes[1 + cnt] = seg_font[mag % 10];
        end
        mag = mag / 10;
        cnt++;
      end while (mag != 0 && cnt < ssd_pkg::DIGITS);
      if (neg && cnt < ssd_pkg::DIGITS && 1 + cnt < ssd_pkg::FRAME_BYTES) begin
        frame_bytes[1 + cnt] = ssd_pkg::SEG_MINUS;
      end
      start_frame(ssd_pkg::FRAME_BYTES);
    end else if (a == ssd_pkg::ACT_RAW) begin
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      frame_bytes[0] = ssd_pkg::CMD_AUTO;
      for (int k = 0; k < 4; k++) begin
        if (1 + k < ssd_pkg::FRAME_BYTES) begin
          frame_bytes[1 + k] = r[8*k +: 8];
        end
      end
      start_frame(ssd_pkg::FRAME_BYTES);
    end else begin
      frame_bytes[0] = b;
      start_frame(1);
    end
    w.clock_line = clk_lv;
    w.data_line  = dat_lv;
    w.busy_res   = (wire_ph != ssd_pkg::PH_IDLE);
    w.frame_done = done;
    w.rejected   = drop;
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input ssd_pkg::act_t a, input logic [14:0] n,
                           input logic [31:0] r, input logic [7:0] b,
                           input logic typed, input line_word_t want);
    int         gap;
    line_word_t pred;
    if (word_count % 180 == 0) begin
      calm = ($urandom_range(0, 2) == 0);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_action          = a;
    in_number          = n;
    in_raw_segments    = r;
    in_brightness_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = step_display(a, n, r, b);
    pending_lines.push_back(typed ? want : pred);
    word_count++;
    @(negedge clk);
  endtask

  task automatic send_random(input ssd_pkg::act_t a);
    send_word(a, rand_number(), $urandom, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // result sink with random backpressure
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    line_word_t got;
    line_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_clock_line, out_data_line, out_busy_res, out_frame_done, out_rejected};
      if (pending_lines.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected word, got %b", $time, got);
      end else begin
        want = pending_lines.pop_front();
        for (int i = 4; i >= 0; i--) begin
          if (got[i] !== want[i]) begin
            err_count++;
            $display("%0t ns: %s expected %b got %b", $time, field_name[i], want[i], got[i]);
          end
        end
      end
    end
  end

  initial begin
    int            start_count;
    int            k;
    ssd_pkg::act_t cmd;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].reps == 0) begin
        while (wire_ph != ssd_pkg::PH_IDLE) send_random(ssd_pkg::ACT_TICK);
      end else begin
        repeat (dir_table[i].reps) begin
          send_word(dir_table[i].act, dir_table[i].num, dir_table[i].raw,
                    dir_table[i].bright, dir_table[i].typed, dir_table[i].want);
        end
      end
    end

    start_count = word_count;
    while (word_count - start_count < N_RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 8) begin
        k   = $urandom_range(0, 19);
        cmd = (k < 9) ? ssd_pkg::ACT_NUMBER : (k < 14) ? ssd_pkg::ACT_RAW : ssd_pkg::ACT_BRIGHT;
        send_random(cmd);
        while (wire_ph != ssd_pkg::PH_IDLE) begin
          if ($urandom_range(0, 39) == 0) begin
            send_random(ssd_pkg::act_t'($urandom_range(1, 3)));
          end else begin
            send_random(ssd_pkg::ACT_TICK);
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_random(ssd_pkg::act_t'($urandom_range(0, 3)));
      end
    end

    in_valid = 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
